// ----- sv/gmsbd_pkg.sv -----
`timescale 1ns / 1ps
package gmsbd_pkg;

	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	localparam int CFG_W = 7;
	localparam int KIND_W = 2;
	localparam int RESULT_W = 13;
	localparam int RESULT_MAX = 4095;

	localparam logic [1:0] CFG_IDX_COLS = 2'd0;
	localparam logic [1:0] CFG_IDX_ROWS = 2'd1;

	localparam logic [1:0] KIND_OPEN = 2'b00;
	localparam logic [1:0] KIND_SOURCE = 2'b01;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_QREAD,
		ST_QLATCH,
		ST_NREAD,
		ST_NCHECK,
		ST_FINISH
	} state_t;

endpackage

// ----- sv/gmsbd_ram.sv -----
`timescale 1ns / 1ps
module gmsbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                  wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                  rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ----- sv/grid_multi_source_bfs_distance.sv -----
`timescale 1ns / 1ps
// Multi-source breadth-first distance over a four-neighbor grid.
// Cells arrive on the cell channel (cell_valid/cell_ready, cell_kind) in
// row-major order, one transfer per cycle while loading. Kind 0 is open,
// kind 1 is a source, and any other pattern is a blocked cell. The grid size
// comes from the configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data): index 0 sets the columns and index 1 the rows; zero is used as
// one and values above the maximum are clamped. Any such write restarts
// loading. Writes are taken only while loading, and no cell is taken in a
// cycle that offers a write. After the last cell the block floods from all
// sources at once, one neighbor at a time: each queued cell (a source or a
// reached cell) is read from the queue through ST_QREAD and ST_QLATCH, then
// each in-bounds neighbor passes ST_NREAD and ST_NCHECK and each neighbor off
// the grid passes ST_NREAD only; an empty queue leads through ST_FINISH.
// One result transfer then leaves on the result channel (result_valid/
// result_ready, farthest_distance): the greatest distance, or -1 if an open
// cell stays unreached. The result sits in an output register, so loading of
// the next grid may start while the receiver stalls; only its last cell waits.
// Reset sets both sizes to 64 and empties the load position and queue; the
// memories are not cleared, since each grid writes every cell it reads.
module grid_multi_source_bfs_distance
	import gmsbd_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       cell_valid,
	output logic                       cell_ready,
	input  logic signed [KIND_W-1:0]   cell_kind,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [RESULT_W-1:0] farthest_distance
);
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SZW = 12;
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int LW = $clog2(CELLS + 2);
	localparam int NW = $clog2(CELLS + 1);
	localparam int DA = RW + CW;
	localparam int DDEPTH = 2 ** DA;
	localparam int DW = LW + 1;
	localparam int QDEPTH = CELLS;
	localparam int QA = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QW = RW + CW + LW;

	// Configuration and clamped sizes.
	logic [CFG_W-1:0] cols_cfg_q, rows_cfg_q;
	logic [SZW-1:0]   cols_eff, rows_eff;
	logic             cfg_fire;

	// Control and datapath registers.
	state_t          state_q, state_d;
	logic [RW-1:0]   ld_row_q, cur_row_q;
	logic [CW-1:0]   ld_col_q, cur_col_q;
	logic [LW-1:0]   cur_lvl_q, max_lvl_q;
	logic [QA:0]     head_q, tail_q;
	logic [NW-1:0]   open_cnt_q, reached_cnt_q;
	logic [1:0]      nb_k_q;
	logic [DA-1:0]   nb_addr_q;
	logic            out_valid_q;
	logic signed [RESULT_W-1:0] out_data_q;

	assign cfg_ready = (state_q == ST_LOAD);
	assign cfg_fire = cfg_valid && cfg_ready
		&& (cfg_index == CFG_IDX_COLS || cfg_index == CFG_IDX_ROWS);

	always_comb begin
		if (cols_cfg_q == '0) begin
			cols_eff = SZW'(1);
		end else if (SZW'(cols_cfg_q) > SZW'(MAX_COLS)) begin
			cols_eff = SZW'(MAX_COLS);
		end else begin
			cols_eff = SZW'(cols_cfg_q);
		end
		if (rows_cfg_q == '0) begin
			rows_eff = SZW'(1);
		end else if (SZW'(rows_cfg_q) > SZW'(MAX_ROWS)) begin
			rows_eff = SZW'(MAX_ROWS);
		end else begin
			rows_eff = SZW'(rows_cfg_q);
		end
	end

	// Memories.
	logic          d_we, q_we;
	logic [DA-1:0] d_waddr, d_raddr;
	logic [DW-1:0] d_wdata, d_rdata;
	logic [QA-1:0] q_waddr, q_raddr;
	logic [QW-1:0] q_wdata, q_rdata;

	gmsbd_ram #(.WIDTH(DW), .DEPTH(DDEPTH)) u_dist_ram (
		.clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
		.rd_addr(d_raddr), .rd_data(d_rdata)
	);

	gmsbd_ram #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue_ram (
		.clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
		.rd_addr(q_raddr), .rd_data(q_rdata)
	);

	// Load position and handshake.
	logic last_cell, cell_fire, is_open, is_source;
	assign last_cell = (SZW'(ld_row_q) == rows_eff - SZW'(1))
		&& (SZW'(ld_col_q) == cols_eff - SZW'(1));
	assign cell_ready = (state_q == ST_LOAD) && !cfg_valid
		&& !(out_valid_q && last_cell);
	assign cell_fire = cell_valid && cell_ready;
	assign is_open = (cell_kind == KIND_OPEN);
	assign is_source = (cell_kind == KIND_SOURCE);

	// Neighbor of the current cell selected by nb_k_q.
	logic          nb_ok;
	logic [RW-1:0] nb_row;
	logic [CW-1:0] nb_col;
	always_comb begin
		nb_row = cur_row_q;
		nb_col = cur_col_q;
		nb_ok = 1'b0;
		case (nb_k_q)
			2'd0: begin
				nb_ok = (cur_row_q != '0);
				nb_row = cur_row_q - RW'(1);
			end
			2'd1: begin
				nb_ok = (SZW'(cur_row_q) + SZW'(1) < rows_eff);
				nb_row = cur_row_q + RW'(1);
			end
			2'd2: begin
				nb_ok = (cur_col_q != '0);
				nb_col = cur_col_q - CW'(1);
			end
			default: begin
				nb_ok = (SZW'(cur_col_q) + SZW'(1) < cols_eff);
				nb_col = cur_col_q + CW'(1);
			end
		endcase
	end

	logic nb_unreached;
	assign nb_unreached = (d_rdata == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (cell_fire && last_cell) begin
					state_d = ST_QREAD;
				end
			end
			ST_QREAD: begin
				state_d = (head_q == tail_q) ? ST_FINISH : ST_QLATCH;
			end
			ST_QLATCH: state_d = ST_NREAD;
			ST_NREAD: begin
				if (nb_ok) begin
					state_d = ST_NCHECK;
				end else if (nb_k_q == 2'd3) begin
					state_d = ST_QREAD;
				end
			end
			ST_NCHECK: state_d = (nb_k_q == 2'd3) ? ST_QREAD : ST_NREAD;
			ST_FINISH: state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// Memory controls.
	always_comb begin
		d_we = 1'b0;
		d_waddr = {ld_row_q, ld_col_q};
		d_wdata = '0;
		d_raddr = {nb_row, nb_col};
		q_we = 1'b0;
		q_waddr = tail_q[QA-1:0];
		q_wdata = {ld_row_q, ld_col_q, LW'(1)};
		q_raddr = head_q[QA-1:0];
		case (state_q)
			ST_LOAD: begin
				d_we = cell_fire;
				d_wdata = is_source ? DW'(1) : (is_open ? DW'(0) : {1'b1, LW'(0)});
				q_we = cell_fire && is_source;
			end
			ST_NCHECK: begin
				d_we = nb_unreached;
				d_waddr = nb_addr_q;
				d_wdata = {1'b0, cur_lvl_q + LW'(1)};
				q_we = nb_unreached;
				q_wdata = {nb_addr_q, cur_lvl_q + LW'(1)};
			end
			default: begin
				d_we = 1'b0;
			end
		endcase
	end

	// Result value.
	logic signed [RESULT_W-1:0] result_val;
	logic [LW-1:0]              dist_val;
	always_comb begin
		dist_val = max_lvl_q - LW'(1);
		if (reached_cnt_q != open_cnt_q) begin
			result_val = -RESULT_W'(1);
		end else if (32'(dist_val) > RESULT_MAX) begin
			result_val = RESULT_W'(RESULT_MAX);
		end else begin
			result_val = RESULT_W'(dist_val);
		end
	end

	assign result_valid = out_valid_q;
	assign farthest_distance = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cols_cfg_q <= CFG_RESET;
			rows_cfg_q <= CFG_RESET;
			ld_row_q <= '0;
			ld_col_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			open_cnt_q <= '0;
			reached_cnt_q <= '0;
			max_lvl_q <= LW'(1);
			nb_k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (cfg_fire) begin
						if (cfg_index == CFG_IDX_COLS) begin
							cols_cfg_q <= cfg_data;
						end else begin
							rows_cfg_q <= cfg_data;
						end
						ld_row_q <= '0;
						ld_col_q <= '0;
						tail_q <= '0;
						open_cnt_q <= '0;
					end else if (cell_fire) begin
						if (is_source) begin
							tail_q <= tail_q + (QA+1)'(1);
						end
						if (is_open) begin
							open_cnt_q <= open_cnt_q + NW'(1);
						end
						if (SZW'(ld_col_q) == cols_eff - SZW'(1)) begin
							ld_col_q <= '0;
							ld_row_q <= last_cell ? '0 : ld_row_q + RW'(1);
						end else begin
							ld_col_q <= ld_col_q + CW'(1);
						end
						head_q <= '0;
						reached_cnt_q <= '0;
						max_lvl_q <= LW'(1);
					end
				end
				ST_QREAD: begin
					if (head_q != tail_q) begin
						head_q <= head_q + (QA+1)'(1);
					end
				end
				ST_QLATCH: begin
					{cur_row_q, cur_col_q, cur_lvl_q} <= q_rdata;
					nb_k_q <= '0;
				end
				ST_NREAD: begin
					nb_addr_q <= {nb_row, nb_col};
					if (!nb_ok) begin
						nb_k_q <= nb_k_q + 2'd1;
					end
				end
				ST_NCHECK: begin
					nb_k_q <= nb_k_q + 2'd1;
					if (nb_unreached) begin
						tail_q <= tail_q + (QA+1)'(1);
						reached_cnt_q <= reached_cnt_q + NW'(1);
						if (cur_lvl_q + LW'(1) > max_lvl_q) begin
							max_lvl_q <= cur_lvl_q + LW'(1);
						end
					end
				end
				ST_FINISH: begin
					out_valid_q <= 1'b1;
					out_data_q <= result_val;
					tail_q <= '0;
					open_cnt_q <= '0;
				end
				default: begin
					nb_k_q <= '0;
				end
			endcase
		end
	end
endmodule

// ----- sim/grid_multi_source_bfs_distance_tb.sv -----
`timescale 1ns / 1ps
module grid_multi_source_bfs_distance_tb;
	import gmsbd_pkg::*;

	// Random phases go on until at least this many random cells have gone in.
	localparam int RANDOM_CELLS = 1350;
	// The run is cut off at this many cycles.
	localparam int CYCLE_LIMIT = 600000;
	// This is how long the receiver holds off once, to back the block up.
	localparam int LONG_HOLD = 3000;
	localparam int GRID_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
	localparam logic [1:0] KIND_BLOCKED = 2'b11;
	localparam logic [1:0] KIND_SPARE = 2'b10;

	// This is one row of the directed table. Cell i sits in kinds[2*i +: 2].
	// Where pinned is set, value is the result as read off by hand.
	typedef struct packed {
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] rows;
		int               count;
		logic [15:0]      kinds;
		bit               pinned;
		int               value;
	} grid_case_t;

	localparam int DIR_ROWS = 10;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       cell_valid;
	logic                       cell_ready;
	logic signed [KIND_W-1:0]   cell_kind;
	logic                       result_valid;
	logic                       result_ready;
	logic signed [RESULT_W-1:0] farthest_distance;

	grid_multi_source_bfs_distance u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cell_valid       (cell_valid),
		.cell_ready       (cell_ready),
		.cell_kind        (cell_kind),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.farthest_distance(farthest_distance)
	);

	// Our own copy of the block: the raw size registers, the levels loaded so
	// far (-1 blocked, 0 open, 1 source) and the sources in arrival order.
	logic [CFG_W-1:0] size_cols;
	logic [CFG_W-1:0] size_rows;
	int               loaded_level [GRID_CELLS];
	int               source_list [$];
	int               load_pos;
	int               distance_q [$];
	bit               pin_next;
	int               pin_value;

	int     mismatches;
	int     cycles;
	int     random_sent;
	int     max_gap;
	bit     hold_long;
	grid_case_t dir_tab [DIR_ROWS];

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int clamp_size(input logic [CFG_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_COLS_DEF)
			return MAX_COLS_DEF;
		return int'(raw);
	endfunction

	// This floods from every source at once and returns the greatest distance.
	// It returns -1 when an open cell is left unreached, and it saturates at
	// the top of the result field.
	function automatic int flood_farthest(input int cols, input int rows);
		int lvl [GRID_CELLS];
		int frontier [GRID_CELLS];
		int head;
		int tail;
		int total;
		int cur;
		int r;
		int c;
		int nr;
		int nc;
		int nxt;
		int best;
		bit unreached;
		total = cols * rows;
		for (int i = 0; i < total; i++)
			lvl[i] = loaded_level[i];
		head = 0;
		tail = 0;
		foreach (source_list[i]) begin
			frontier[tail] = source_list[i];
			tail++;
		end
		while (head < tail) begin
			cur = frontier[head];
			head++;
			r = cur / cols;
			c = cur % cols;
			// The neighbors are taken in the order up, down, left, right.
			for (int k = 0; k < 4; k++) begin
				nr = r + ((k == 0) ? -1 : (k == 1) ? 1 : 0);
				nc = c + ((k == 2) ? -1 : (k == 3) ? 1 : 0);
				if (nr < 0 || nr >= rows || nc < 0 || nc >= cols)
					continue;
				nxt = nr * cols + nc;
				if (lvl[nxt] != 0)
					continue;
				lvl[nxt] = lvl[cur] + 1;
				frontier[tail] = nxt;
				tail++;
			end
		end
		// The maximum starts at the source level, so a grid with no open
		// cell gives 0.
		best = 1;
		unreached = 0;
		for (int i = 0; i < total; i++) begin
			if (lvl[i] == 0)
				unreached = 1;
			if (lvl[i] > best)
				best = lvl[i];
		end
		if (unreached)
			return -1;
		if (best - 1 > RESULT_MAX)
			return RESULT_MAX;
		return best - 1;
	endfunction

	// The predictor follows each accepted transfer. A write to either size
	// register drops any partly loaded grid. The last cell of a grid yields one
	// expected distance.
	always @(posedge clk) begin
		int total;
		int lvl;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IDX_COLS)
					size_cols = cfg_data;
				if (cfg_index == CFG_IDX_ROWS)
					size_rows = cfg_data;
				if (cfg_index == CFG_IDX_COLS || cfg_index == CFG_IDX_ROWS) begin
					load_pos = 0;
					source_list.delete();
				end
			end
			if (cell_valid && cell_ready) begin
				total = clamp_size(size_cols) * clamp_size(size_rows);
				// The spare pattern is treated as a blocked cell.
				lvl = (cell_kind == KIND_OPEN) ? 0 : (cell_kind == KIND_SOURCE) ? 1 : -1;
				loaded_level[load_pos] = lvl;
				if (lvl == 1)
					source_list.push_back(load_pos);
				load_pos++;
				if (load_pos >= total) begin
					if (pin_next)
						distance_q.push_back(pin_value);
					else
						distance_q.push_back(flood_farthest(clamp_size(size_cols),
							clamp_size(size_rows)));
					pin_next = 0;
					load_pos = 0;
					source_list.delete();
				end
			end
		end
	end

	// Each result transfer is checked against the oldest expected distance.
	always @(posedge clk) begin
		logic [RESULT_W-1:0] want;
		if (arst_n && result_valid && result_ready) begin
			if (distance_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", farthest_distance));
			end else begin
				want = RESULT_W'(distance_q.pop_front());
				if (farthest_distance !== want)
					report_mismatch($sformatf("farthest_distance %0d, expected %0d",
						farthest_distance, $signed(want)));
			end
		end
	end

	// The receiver waits a random number of cycles before each result. Once,
	// it waits a long stretch while the sender keeps offering cells.
	initial begin
		int gap;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(max_gap);
			if (hold_long) begin
				gap = LONG_HOLD;
				hold_long = 0;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// This is the watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL grid_multi_source_bfs_distance");
			$finish;
		end
	end

	// All tasks below start and end at a falling edge.
	task automatic send_cell(input logic [1:0] kind);
		int gap;
		gap = $urandom_range(max_gap);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cell_valid <= 1'b1;
		cell_kind <= kind;
		do @(posedge clk); while (!cell_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		cell_valid <= 1'b0;
		while (distance_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The write stays offered until the caller drops cfg_valid, so that
	// writes can follow one another.
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
		drain_results();
		write_reg(CFG_IDX_COLS, cols);
		write_reg(CFG_IDX_ROWS, rows);
		cfg_valid <= 1'b0;
	endtask

	// This draws a cell with the given percentages of sources and blocked
	// cells. Now and then a blocked cell uses the spare pattern.
	function automatic logic [1:0] draw_kind(input int src_pct, input int blk_pct);
		int r;
		r = $urandom_range(99);
		if (r < src_pct)
			return KIND_SOURCE;
		if (r < src_pct + blk_pct)
			return ($urandom_range(7) == 0) ? KIND_SPARE : KIND_BLOCKED;
		return KIND_OPEN;
	endfunction

	initial begin
		int cols;
		int rows;
		int grids;
		int src_pct;
		int blk_pct;
		int total;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cell_valid = 1'b0;
		cell_kind = '0;
		size_cols = CFG_RESET;
		size_rows = CFG_RESET;
		load_pos = 0;
		pin_next = 0;
		pin_value = 0;
		mismatches = 0;
		cycles = 0;
		random_sent = 0;
		max_gap = 15;
		hold_long = 0;

		// These are the directed grids. The pinned values are read straight
		// off the grid.
		dir_tab[0] = '{7'd1, 7'd1, 1, 16'h0001, 1'b1, 0};
		dir_tab[1] = '{7'd1, 7'd1, 1, 16'h0003, 1'b1, 0};
		dir_tab[2] = '{7'd1, 7'd1, 1, 16'h0000, 1'b1, -1};
		dir_tab[3] = '{7'd1, 7'd1, 1, 16'h0002, 1'b1, 0};
		dir_tab[4] = '{7'd3, 7'd1, 3, 16'h0001, 1'b1, 2};
		dir_tab[5] = '{7'd2, 7'd2, 4, 16'h003D, 1'b1, -1};
		// Zero sizes are used as one.
		dir_tab[6] = '{7'd0, 7'd0, 1, 16'h0001, 1'b1, 0};
		dir_tab[7] = '{7'd4, 7'd2, 8, 16'h4001, 1'b0, 0};
		dir_tab[8] = '{7'd2, 7'd3, 6, 16'h0FFF, 1'b1, 0};
		dir_tab[9] = '{7'd1, 7'd4, 4, 16'h0055, 1'b1, 0};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int t = 0; t < DIR_ROWS; t++) begin
			set_size(dir_tab[t].cols, dir_tab[t].rows);
			pin_next = dir_tab[t].pinned;
			pin_value = dir_tab[t].value;
			for (int i = 0; i < dir_tab[t].count; i++)
				send_cell(dir_tab[t].kinds[2*i +: 2]);
		end

		// Writes to the unused indexes must change nothing.
		drain_results();
		write_reg(2'd2, 7'h7F);
		write_reg(2'd3, 7'h55);
		cfg_valid <= 1'b0;
		for (int i = 0; i < 4; i++)
			send_cell(KIND_OPEN);

		// In the first random phase the receiver holds off for a long
		// stretch over several small grids, so that the block stalls.
		hold_long = 1;
		for (int phase_no = 0; random_sent < RANDOM_CELLS; phase_no++) begin
			cols = $urandom_range(1, 8);
			rows = $urandom_range(1, 8);
			if (phase_no > 0 && $urandom_range(7) == 0) begin
				// These are the extreme settings: a full-width row or column,
				// a zero size, or a value far above the maximum.
				case ($urandom_range(3))
					0: begin cols = 127; rows = $urandom_range(0, 2); end
					1: begin cols = $urandom_range(0, 1); rows = 127; end
					2: begin cols = 64; rows = 1; end
					default: begin cols = 0; rows = 64; end
				endcase
			end
			// Some phases run with no idling at all on either side.
			max_gap = ($urandom_range(3) == 0) ? 0 : 15;
			set_size(cols[CFG_W-1:0], rows[CFG_W-1:0]);
			total = clamp_size(cols[CFG_W-1:0]) * clamp_size(rows[CFG_W-1:0]);
			grids = (phase_no == 0) ? 6 : $urandom_range(1, 5);
			for (int g = 0; g < grids; g++) begin
				src_pct = $urandom_range(1, 25);
				blk_pct = $urandom_range(0, 40);
				for (int i = 0; i < total; i++) begin
					send_cell(draw_kind(src_pct, blk_pct));
					random_sent++;
				end
			end
		end

		drain_results();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && distance_q.size() == 0) begin
			$display("PASS grid_multi_source_bfs_distance");
		end else begin
			$display("FAIL grid_multi_source_bfs_distance");
		end
		$finish;
	end

endmodule
